// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS + 1);

    // last pointer values of the copy and fill loops
    localparam int COPY_LAST  = COLUMNS * (ROWS - 1) - 1;
    localparam int FILL_LAST  = CELL_COUNT - 1;

    // beat field widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int X_W        = 7;
    localparam int Y_W        = 5;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;

    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUT_CUR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT_POS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    // pointer operations
    localparam logic [2:0] PTR_HOLD   = 3'd0;
    localparam logic [2:0] PTR_ZERO   = 3'd1;
    localparam logic [2:0] PTR_INC    = 3'd2;
    localparam logic [2:0] PTR_CURSOR = 3'd3;
    localparam logic [2:0] PTR_POS    = 3'd4;

    // write data sources
    localparam logic [1:0] WS_ZERO  = 2'd0;
    localparam logic [1:0] WS_CELL  = 2'd1;
    localparam logic [1:0] WS_RDATA = 2'd2;

    // read address sources
    localparam logic [1:0] RS_PTR       = 2'd0;
    localparam logic [1:0] RS_NEXT_ROW  = 2'd1;
    localparam logic [1:0] RS_NEXT_ROW1 = 2'd2;

    // cursor operations
    localparam logic [1:0] CUR_HOLD    = 2'd0;
    localparam logic [1:0] CUR_ADVANCE = 2'd1;
    localparam logic [1:0] CUR_NEWLINE = 2'd2;
    localparam logic [1:0] CUR_SCROLL  = 2'd3;

    // jump conditions
    localparam logic [2:0] J_NONE        = 3'd0;
    localparam logic [2:0] J_ALWAYS      = 3'd1;
    localparam logic [2:0] J_CH_ZERO     = 3'd2;
    localparam logic [2:0] J_CH_NL       = 3'd3;
    localparam logic [2:0] J_OUT_RANGE   = 3'd4;
    localparam logic [2:0] J_NO_OVF      = 3'd5;
    localparam logic [2:0] J_PTR_NE_COPY = 3'd6;
    localparam logic [2:0] J_PTR_NE_FILL = 3'd7;

    // microprogram steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
    localparam logic [STEP_W-1:0] S_CLR      = 5'd1;
    localparam logic [STEP_W-1:0] S_FILL     = 5'd2;
    localparam logic [STEP_W-1:0] S_PC_CHK0  = 5'd3;
    localparam logic [STEP_W-1:0] S_PC_CHKNL = 5'd4;
    localparam logic [STEP_W-1:0] S_PC_WR    = 5'd5;
    localparam logic [STEP_W-1:0] S_PC_NL    = 5'd6;
    localparam logic [STEP_W-1:0] S_PC_OVF   = 5'd7;
    localparam logic [STEP_W-1:0] S_PC_SCR   = 5'd8;
    localparam logic [STEP_W-1:0] S_PC_EMIT  = 5'd9;
    localparam logic [STEP_W-1:0] S_SC_ZERO  = 5'd10;
    localparam logic [STEP_W-1:0] S_SC_PRIME = 5'd11;
    localparam logic [STEP_W-1:0] S_SC_COPY  = 5'd12;
    localparam logic [STEP_W-1:0] S_SC_TAIL  = 5'd13;
    localparam logic [STEP_W-1:0] S_EMIT0    = 5'd14;
    localparam logic [STEP_W-1:0] S_PP_CHK0  = 5'd15;
    localparam logic [STEP_W-1:0] S_PP_RANGE = 5'd16;
    localparam logic [STEP_W-1:0] S_PP_WR    = 5'd17;
    localparam logic [STEP_W-1:0] S_RD_ADDR  = 5'd18;
    localparam logic [STEP_W-1:0] S_RD_ISSUE = 5'd19;
    localparam logic [STEP_W-1:0] S_RD_EMIT  = 5'd20;

    typedef struct packed {
        logic [2:0]        ptr_op;
        logic              we;
        logic [1:0]        wsrc;
        logic [1:0]        rsel;
        logic [1:0]        cur_op;
        logic              emit;
        logic              cell_rd;
        logic [2:0]        jcond;
        logic [STEP_W-1:0] jtarget;
        logic              last;
    } t_ctrl;

    typedef struct packed {
        logic ch_zero;
        logic ch_nl;
        logic out_range;
        logic row_ovf;
        logic ptr_copy_last;
        logic ptr_fill_last;
        logic out_busy;
    } t_stat;

    // entry step of each command
    function automatic logic [STEP_W-1:0] f_entry(input logic [CMD_W-1:0] cmd);
        logic [STEP_W-1:0] s;
        case (cmd)
            CMD_PUT_CUR: s = S_PC_CHK0;
            CMD_PUT_POS: s = S_PP_CHK0;
            CMD_CLEAR:   s = S_CLR;
            default:     s = S_RD_ADDR;
        endcase
        return s;
    endfunction

    // control store
    function automatic t_ctrl f_ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '0;
        case (step)
            S_IDLE: begin
            end
            S_CLR: begin
                w.ptr_op = PTR_ZERO;
            end
            S_FILL: begin
                w.we      = 1'b1;
                w.wsrc    = WS_ZERO;
                w.ptr_op  = PTR_INC;
                w.jcond   = J_PTR_NE_FILL;
                w.jtarget = S_FILL;
                w.last    = 1'b1;
            end
            S_PC_CHK0: begin
                w.ptr_op  = PTR_CURSOR;
                w.jcond   = J_CH_ZERO;
                w.jtarget = S_IDLE;
            end
            S_PC_CHKNL: begin
                w.jcond   = J_CH_NL;
                w.jtarget = S_PC_NL;
            end
            S_PC_WR: begin
                w.we      = 1'b1;
                w.wsrc    = WS_CELL;
                w.cur_op  = CUR_ADVANCE;
                w.jcond   = J_ALWAYS;
                w.jtarget = S_PC_OVF;
            end
            S_PC_NL: begin
                w.cur_op = CUR_NEWLINE;
            end
            S_PC_OVF: begin
                w.jcond   = J_NO_OVF;
                w.jtarget = S_EMIT0;
            end
            S_PC_SCR: begin
                w.cur_op = CUR_SCROLL;
            end
            S_PC_EMIT: begin
                w.emit = 1'b1;
            end
            S_SC_ZERO: begin
                w.ptr_op = PTR_ZERO;
            end
            S_SC_PRIME: begin
                w.rsel = RS_NEXT_ROW;
            end
            S_SC_COPY: begin
                w.rsel    = RS_NEXT_ROW1;
                w.we      = 1'b1;
                w.wsrc    = WS_RDATA;
                w.ptr_op  = PTR_INC;
                w.jcond   = J_PTR_NE_COPY;
                w.jtarget = S_SC_COPY;
            end
            S_SC_TAIL: begin
                w.jcond   = J_ALWAYS;
                w.jtarget = S_FILL;
            end
            S_EMIT0: begin
                w.emit = 1'b1;
                w.last = 1'b1;
            end
            S_PP_CHK0: begin
                w.ptr_op  = PTR_POS;
                w.jcond   = J_CH_ZERO;
                w.jtarget = S_IDLE;
            end
            S_PP_RANGE: begin
                w.jcond   = J_OUT_RANGE;
                w.jtarget = S_EMIT0;
            end
            S_PP_WR: begin
                w.we      = 1'b1;
                w.wsrc    = WS_CELL;
                w.jcond   = J_ALWAYS;
                w.jtarget = S_EMIT0;
            end
            S_RD_ADDR: begin
                w.ptr_op = PTR_POS;
            end
            S_RD_ISSUE: begin
                w.rsel = RS_PTR;
            end
            S_RD_EMIT: begin
                w.emit    = 1'b1;
                w.cell_rd = 1'b1;
                w.last    = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/text_console_writer.sv -----
// channel   dir  beat contents                                  accepted when
// s_axis    in   tuser: command; tdata: char, pos_x, pos_y       tvalid && tready
// m_axis    out  tdata: cursor_pos, cell_word                    tvalid && tready
// cfg       in   i_cfg_wdata: text_color                        i_cfg_we high
//
// a scroll moves rows 1 to ROWS-1 up by one row and then clears the bottom row,
//   all through the single write port of the screen ram
// clear command clears one cell per cycle
// reset runs the same clearing pass with s_axis_tready low
// the result sits in an output register; a stalled m_axis holds only the step that
//   emits, and one new beat is taken per command once the sequencer is back at idle
module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command beat
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], pos_x[14:8], pos_y[19:15], zero
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    // result beat
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cursor_pos[10:0], cell_word[26:11], zero
    // text color register
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import tcw_pkg::*;

    t_ctrl             w_ctrl;
    t_stat             w_stat;
    logic              w_ready;
    logic              w_load;
    logic [POS_W-1:0]  w_cursor_pos;
    logic [CELL_W-1:0] w_cell_word;

    // beat is taken only at idle step of the microprogram
    assign w_load        = s_axis_tvalid && w_ready;
    assign s_axis_tready = w_ready;

    // step counter, control store and jump logic
    tcw_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser[CMD_W-1:0]),
        .i_stat     (w_stat),
        .o_in_ready (w_ready),
        .o_ctrl     (w_ctrl)
    );

    // cursor, screen ram, output register
    tcw_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_load       (w_load),
        .i_char_code  (s_axis_tdata[CHAR_W-1:0]),
        .i_pos_x      (s_axis_tdata[CHAR_W+X_W-1:CHAR_W]),
        .i_pos_y      (s_axis_tdata[CHAR_W+X_W+Y_W-1:CHAR_W+X_W]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (m_axis_tready),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .o_cursor_pos (w_cursor_pos),
        .o_cell_word  (w_cell_word)
    );

    // pack result fields, low field first
    assign m_axis_tdata = {5'd0, w_cell_word, w_cursor_pos};

endmodule

// ----- hdl/tcw_ram.sv -----
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tcw_sequencer.sv -----
module tcw_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [tcw_pkg::CMD_W-1:0] i_cmd,
    input  tcw_pkg::t_stat            i_stat,
    output logic                      o_in_ready,
    output tcw_pkg::t_ctrl            o_ctrl
);
    import tcw_pkg::*;

    logic [STEP_W-1:0] r_upc;
    logic [STEP_W-1:0] n_upc;
    t_ctrl             v_word;
    logic              v_jump;
    logic              v_stall;

    assign v_word  = f_ucode(r_upc);
    // emit waits while the previous result is still held
    assign v_stall = v_word.emit && i_stat.out_busy;

    always_comb begin
        case (v_word.jcond)
            J_ALWAYS:      v_jump = 1'b1;
            J_CH_ZERO:     v_jump = i_stat.ch_zero;
            J_CH_NL:       v_jump = i_stat.ch_nl;
            J_OUT_RANGE:   v_jump = i_stat.out_range;
            J_NO_OVF:      v_jump = !i_stat.row_ovf;
            J_PTR_NE_COPY: v_jump = !i_stat.ptr_copy_last;
            J_PTR_NE_FILL: v_jump = !i_stat.ptr_fill_last;
            default:       v_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (r_upc == S_IDLE) begin
            if (i_in_valid) begin
                n_upc = f_entry(i_cmd);
            end
        end else if (v_stall) begin
            n_upc = r_upc;
        end else if (v_jump) begin
            n_upc = v_word.jtarget;
        end else if (v_word.last) begin
            n_upc = S_IDLE;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        o_ctrl = v_word;
        if (v_stall) begin
            o_ctrl.emit = 1'b0;
        end
    end

    assign o_in_ready = (r_upc == S_IDLE);

endmodule

// ----- hdl/tcw_datapath.sv -----
module tcw_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcw_pkg::t_ctrl              i_ctrl,
    input  logic                        i_load,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::X_W-1:0]     i_pos_x,
    input  logic [tcw_pkg::Y_W-1:0]     i_pos_y,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0] i_cfg_wdata,
    input  logic                        i_out_ready,
    output tcw_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_word
);
    import tcw_pkg::*;

    logic [ADDR_W-1:0]  r_ptr;
    logic [ADDR_W-1:0]  n_ptr;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   n_row;
    logic [COLOR_W-1:0] r_color;
    logic [CHAR_W-1:0]  r_ch;
    logic [X_W-1:0]     r_x;
    logic [Y_W-1:0]     r_y;
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [CELL_W-1:0]  r_out_cell;

    logic [31:0]        v_lin;
    logic [31:0]        v_pos;
    logic               v_in_range;
    logic [CELL_W-1:0]  v_wdata;
    logic [ADDR_W-1:0]  v_raddr;
    logic [CELL_W-1:0]  w_rdata;

    assign v_lin      = 32'(r_col) + 32'(r_row) * 32'(COLUMNS);
    assign v_pos      = 32'(r_x) + 32'(r_y) * 32'(COLUMNS);
    assign v_in_range = (32'(r_x) < 32'(COLUMNS)) && (32'(r_y) < 32'(ROWS));

    always_comb begin
        case (i_ctrl.ptr_op)
            PTR_ZERO:   n_ptr = '0;
            PTR_INC:    n_ptr = r_ptr + 1'b1;
            PTR_CURSOR: n_ptr = v_lin[ADDR_W-1:0];
            PTR_POS:    n_ptr = v_pos[ADDR_W-1:0];
            default:    n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        case (i_ctrl.cur_op)
            CUR_ADVANCE: begin
                if (32'(r_col) == 32'(COLUMNS - 1)) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            CUR_NEWLINE: begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end
            CUR_SCROLL: begin
                n_col = '0;
                n_row = ROW_W'(ROWS - 1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (i_ctrl.wsrc)
            WS_CELL:  v_wdata = {r_color, r_ch};
            WS_RDATA: v_wdata = w_rdata;
            default:  v_wdata = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.rsel)
            RS_NEXT_ROW:  v_raddr = ADDR_W'(32'(r_ptr) + 32'(COLUMNS));
            RS_NEXT_ROW1: v_raddr = ADDR_W'(32'(r_ptr) + 32'(COLUMNS) + 32'd1);
            default:      v_raddr = r_ptr;
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.we),
        .i_waddr (r_ptr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= COLOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (i_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_load) begin
            r_ch <= i_char_code;
            r_x  <= i_pos_x;
            r_y  <= i_pos_y;
        end
        if (i_ctrl.emit) begin
            r_out_pos  <= v_lin[POS_W-1:0];
            r_out_cell <= (i_ctrl.cell_rd && v_in_range) ? w_rdata : '0;
        end
    end

    always_comb begin
        o_stat.ch_zero       = (r_ch == '0);
        o_stat.ch_nl         = (r_ch == CHAR_NEWLINE);
        o_stat.out_range     = !v_in_range;
        o_stat.row_ovf       = (32'(r_row) >= 32'(ROWS));
        o_stat.ptr_copy_last = (32'(r_ptr) == 32'(COPY_LAST));
        o_stat.ptr_fill_last = (32'(r_ptr) == 32'(FILL_LAST));
        o_stat.out_busy      = r_out_valid && !i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_word  = r_out_cell;

endmodule
